[hdl/emfd_pkg.sv]
// Shared types, constants and helpers for the energy meter frame decoder.
// Used by every module of the block; depends on nothing else.
`default_nettype none
package emfd_pkg;

    // Fixed point fraction bits of the measure-mode quotients (range 0 to 16).
    localparam int FRAC_BITS = 8;

    localparam int BYTE_W  = 8;
    localparam int WORD_W  = 24;
    localparam int K_W     = 32;
    localparam int VAL_W   = 40;
    localparam int DIV_W   = K_W + FRAC_BITS;
    localparam int SAT_W   = K_W + 16;
    localparam int CNT_W   = $clog2(DIV_W);
    localparam int FACT_W  = 12;
    localparam int NUM_WORDS = 6;
    localparam int IDX_W   = 5;
    localparam int WSEL_W  = 3;
    localparam int CFG_IDX_W = 2;

    // Frame byte positions.
    localparam logic [IDX_W-1:0] IDX_CHECK = IDX_W'(1);
    localparam logic [IDX_W-1:0] IDX_FIRST_WORD = IDX_W'(2);
    localparam logic [IDX_W-1:0] IDX_LAST_WORD = IDX_W'(19);
    localparam logic [IDX_W-1:0] IDX_ENABLE = IDX_W'(20);

    // Byte codes.
    localparam logic [BYTE_W-1:0] CHECK_GOOD  = 8'h5A;
    localparam logic [BYTE_W-1:0] STATE_OK_A  = 8'h55;
    localparam logic [BYTE_W-1:0] STATE_OK_B  = 8'hF2;
    localparam logic [BYTE_W-1:0] STATE_UNCAL = 8'hAA;
    localparam logic [BYTE_W-1:0] EN_VOLTAGE  = 8'h40;
    localparam logic [BYTE_W-1:0] EN_CURRENT  = 8'h20;
    localparam logic [BYTE_W-1:0] EN_POWER    = 8'h10;

    // Result status codes.
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_BAD_CHECK = 2'd1;
    localparam logic [1:0] STATUS_UNCAL     = 2'd2;
    localparam logic [1:0] STATUS_UNKNOWN   = 2'd3;

    // Configuration register indexes and reset values.
    localparam logic [CFG_IDX_W-1:0] CFG_VOLTAGE_K = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CURRENT_K = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_POWER_K   = 2'd2;
    localparam logic [K_W-1:0] VOLTAGE_K_RST = 32'd2553320;
    localparam logic [K_W-1:0] CURRENT_K_RST = 32'd32540;
    localparam logic [K_W-1:0] POWER_K_RST   = 32'd140960600;

    // Calibrate-mode multipliers.
    localparam logic [FACT_W-1:0] FACT_VOLTAGE = 12'd220;
    localparam logic [FACT_W-1:0] FACT_CURRENT = 12'd10;
    localparam logic [FACT_W-1:0] FACT_POWER   = 12'd2200;

    // Channel codes used by the back end.
    localparam logic [1:0] CH_VOLTAGE = 2'd0;
    localparam logic [1:0] CH_CURRENT = 2'd1;
    localparam logic [1:0] CH_POWER   = 2'd2;

    localparam logic [VAL_W-1:0] VAL_MAX = '1;

    typedef struct packed {
        logic [K_W-1:0] voltage_k;
        logic [K_W-1:0] current_k;
        logic [K_W-1:0] power_k;
    } cfg_t;

    // One decoded frame waiting for its values. Word order follows the frame:
    // voltage coef, voltage reg, current coef, current reg, power coef, power reg.
    typedef struct packed {
        logic                              calib;
        logic [1:0]                        status;
        logic [2:0]                        mask;
        logic [NUM_WORDS-1:0][WORD_W-1:0]  words;
    } job_t;

    typedef struct packed {
        logic [WORD_W-1:0] power_coef;
        logic [WORD_W-1:0] current_coef;
        logic [WORD_W-1:0] voltage_coef;
        logic [WORD_W-1:0] power_reg;
        logic [WORD_W-1:0] current_reg;
        logic [WORD_W-1:0] voltage_reg;
        logic [VAL_W-1:0]  power_value;
        logic [VAL_W-1:0]  current_value;
        logic [VAL_W-1:0]  voltage_value;
        logic [2:0]        updated_mask;
        logic [1:0]        status;
    } result_t;

    // Clamps a quotient to the width of a result value.
    function automatic logic [VAL_W-1:0] sat_value(input logic [DIV_W-1:0] q);
        logic [SAT_W-1:0] qx;
        qx = SAT_W'(q);
        if (qx > SAT_W'(VAL_MAX))
            return VAL_MAX;
        else
            return qx[VAL_W-1:0];
    endfunction

endpackage
`default_nettype wire

[hdl/emfd_front.sv]
// Front end of the frame decoder: accepts bytes, tracks the frame position,
// collects the header and six words and builds one job per frame. Uses emfd_pkg.
`default_nettype none
module emfd_front
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_accept,
    input  wire logic                         command,
    input  wire logic [emfd_pkg::BYTE_W-1:0]  data_byte,
    input  wire logic                         frame_start,
    output logic                              push,
    output emfd_pkg::job_t                    push_job
);

    logic [emfd_pkg::IDX_W-1:0]  idx_reg, idx_next;
    logic                        open_reg, open_next;
    logic                        mode_reg, mode_next;
    logic [emfd_pkg::BYTE_W-1:0] state_reg, state_next;
    logic [emfd_pkg::BYTE_W-1:0] check_reg, check_next;
    logic [emfd_pkg::WSEL_W-1:0] wsel_reg, wsel_next;
    logic [1:0]                  sub_reg, sub_next;
    logic [emfd_pkg::NUM_WORDS-1:0][emfd_pkg::WORD_W-1:0] words_reg;
    logic                        word_we;
    logic [1:0]                  status;

    always_comb
    begin
        idx_next   = idx_reg;
        open_next  = open_reg;
        mode_next  = mode_reg;
        state_next = state_reg;
        check_next = check_reg;
        wsel_next  = wsel_reg;
        sub_next   = sub_reg;
        word_we    = 1'b0;
        push       = 1'b0;
        if (in_accept)
        begin
            if (frame_start)
            begin
                open_next  = 1'b1;
                mode_next  = command;
                state_next = data_byte;
                idx_next   = emfd_pkg::IDX_CHECK;
            end
            else if (open_reg)
            begin
                if (idx_reg == emfd_pkg::IDX_CHECK)
                begin
                    check_next = data_byte;
                    idx_next   = emfd_pkg::IDX_FIRST_WORD;
                    wsel_next  = '0;
                    sub_next   = '0;
                end
                else if (idx_reg >= emfd_pkg::IDX_FIRST_WORD &&
                         idx_reg <= emfd_pkg::IDX_LAST_WORD)
                begin
                    word_we  = 1'b1;
                    idx_next = idx_reg + 1'b1;
                    if (sub_reg == 2'd2)
                    begin
                        sub_next  = '0;
                        wsel_next = wsel_reg + 1'b1;
                    end
                    else
                    begin
                        sub_next = sub_reg + 1'b1;
                    end
                end
                else
                begin
                    // Enable byte closes the frame and hands it to the back end.
                    push      = 1'b1;
                    open_next = 1'b0;
                    idx_next  = '0;
                end
            end
        end
    end

    always_comb
    begin
        priority if (check_reg != emfd_pkg::CHECK_GOOD)
            status = emfd_pkg::STATUS_BAD_CHECK;
        else if (state_reg == emfd_pkg::STATE_OK_A || state_reg == emfd_pkg::STATE_OK_B)
            status = emfd_pkg::STATUS_OK;
        else if (state_reg == emfd_pkg::STATE_UNCAL)
            status = emfd_pkg::STATUS_UNCAL;
        else
            status = emfd_pkg::STATUS_UNKNOWN;
    end

    always_comb
    begin
        push_job.calib  = mode_reg;
        push_job.status = status;
        push_job.words  = words_reg;
        if (status == emfd_pkg::STATUS_OK)
            push_job.mask = {(data_byte & emfd_pkg::EN_VOLTAGE) != '0,
                             (data_byte & emfd_pkg::EN_CURRENT) != '0,
                             (data_byte & emfd_pkg::EN_POWER) != '0};
        else
            push_job.mask = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            open_reg  <= 1'b0;
            mode_reg  <= 1'b0;
            state_reg <= '0;
            check_reg <= '0;
            wsel_reg  <= '0;
            sub_reg   <= '0;
        end
        else
        begin
            idx_reg   <= idx_next;
            open_reg  <= open_next;
            mode_reg  <= mode_next;
            state_reg <= state_next;
            check_reg <= check_next;
            wsel_reg  <= wsel_next;
            sub_reg   <= sub_next;
        end
    end

    // Words shift in big-endian, one byte at a time.
    always_ff @(posedge clk)
    begin
        if (word_we)
            words_reg[wsel_reg] <= {words_reg[wsel_reg][emfd_pkg::WORD_W-emfd_pkg::BYTE_W-1:0],
                                    data_byte};
    end

endmodule
`default_nettype wire

[hdl/emfd_queue.sv]
// Two-entry job queue between the front and back ends of the frame decoder.
// Uses the job type of emfd_pkg.
`default_nettype none
module emfd_queue
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    input  emfd_pkg::job_t push_job,
    input  wire logic      pop,
    output logic           full,
    output logic           not_empty,
    output emfd_pkg::job_t head_job
);

    emfd_pkg::job_t mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_pop;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head_job  = mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_job;
    end

endmodule
`default_nettype wire

[hdl/emfd_back.sv]
// Back end of the frame decoder: takes jobs from the queue, works out the three
// values with one shared restoring divider and multiplier, and holds the result.
// Uses emfd_pkg.
`default_nettype none
module emfd_back
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  emfd_pkg::cfg_t   cfg,
    input  wire logic        job_avail,
    input  emfd_pkg::job_t   head_job,
    output logic             pop,
    output logic             out_valid,
    input  wire logic        out_ready,
    output emfd_pkg::result_t out_result
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SEL  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]                    st_reg, st_next;
    logic [1:0]                    ch_reg, ch_next;
    emfd_pkg::job_t                job_reg, job_next;
    logic [emfd_pkg::VAL_W-1:0]    vals_reg [3];
    logic [emfd_pkg::VAL_W-1:0]    vals_next [3];
    logic [emfd_pkg::WORD_W-1:0]   rem_reg, rem_next;
    logic [emfd_pkg::DIV_W-1:0]    quo_reg, quo_next;
    logic [emfd_pkg::CNT_W-1:0]    cnt_reg, cnt_next;
    logic                          out_valid_reg, out_valid_next;
    emfd_pkg::result_t             out_reg, out_next;

    logic [emfd_pkg::K_W-1:0]      k_sel;
    logic [emfd_pkg::WORD_W-1:0]   dvs;
    logic [emfd_pkg::FACT_W-1:0]   factor;
    logic                          en;
    logic [emfd_pkg::WORD_W+emfd_pkg::FACT_W-1:0] product;
    logic [emfd_pkg::WORD_W:0]     sh, diff;
    logic                          ge;
    logic [emfd_pkg::WORD_W-1:0]   rem_step;
    logic [emfd_pkg::DIV_W-1:0]    quo_step;
    logic                          last_ch;
    logic                          out_free;

    // Per-channel operands.
    always_comb
    begin
        unique case (ch_reg)
            emfd_pkg::CH_VOLTAGE:
            begin
                k_sel  = cfg.voltage_k;
                dvs    = job_reg.words[1];
                factor = emfd_pkg::FACT_VOLTAGE;
                en     = job_reg.mask[2];
            end
            emfd_pkg::CH_CURRENT:
            begin
                k_sel  = cfg.current_k;
                dvs    = job_reg.words[3];
                factor = emfd_pkg::FACT_CURRENT;
                en     = job_reg.mask[1];
            end
            emfd_pkg::CH_POWER:
            begin
                k_sel  = cfg.power_k;
                dvs    = job_reg.words[5];
                factor = emfd_pkg::FACT_POWER;
                en     = job_reg.mask[0];
            end
            default:
            begin
                k_sel  = '0;
                dvs    = '0;
                factor = '0;
                en     = 1'b0;
            end
        endcase
    end

    assign product  = dvs * factor;
    assign sh       = {rem_reg, quo_reg[emfd_pkg::DIV_W-1]};
    assign diff     = sh - {1'b0, dvs};
    assign ge       = (sh >= {1'b0, dvs});
    assign rem_step = ge ? diff[emfd_pkg::WORD_W-1:0] : sh[emfd_pkg::WORD_W-1:0];
    assign quo_step = {quo_reg[emfd_pkg::DIV_W-2:0], ge};
    assign last_ch  = (ch_reg == emfd_pkg::CH_POWER);
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        st_next        = st_reg;
        ch_next        = ch_reg;
        job_next       = job_reg;
        vals_next      = vals_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        cnt_next       = cnt_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !out_ready;
        pop            = 1'b0;

        unique case (st_reg)
            ST_IDLE:
            begin
                if (job_avail)
                begin
                    pop      = 1'b1;
                    job_next = head_job;
                    ch_next  = emfd_pkg::CH_VOLTAGE;
                    st_next  = ST_SEL;
                end
            end
            ST_SEL:
            begin
                if (!en || job_reg.calib || dvs == '0)
                begin
                    priority if (!en)
                        vals_next[ch_reg] = '0;
                    else if (job_reg.calib)
                        vals_next[ch_reg] = emfd_pkg::VAL_W'(product);
                    else
                        vals_next[ch_reg] = emfd_pkg::VAL_MAX;
                    if (last_ch)
                        st_next = ST_DONE;
                    else
                        ch_next = ch_reg + 1'b1;
                end
                else
                begin
                    rem_next = '0;
                    quo_next = emfd_pkg::DIV_W'(k_sel) << emfd_pkg::FRAC_BITS;
                    cnt_next = emfd_pkg::CNT_W'(emfd_pkg::DIV_W - 1);
                    st_next  = ST_DIV;
                end
            end
            ST_DIV:
            begin
                rem_next = rem_step;
                quo_next = quo_step;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    vals_next[ch_reg] = emfd_pkg::sat_value(quo_step);
                    if (last_ch)
                    begin
                        st_next = ST_DONE;
                    end
                    else
                    begin
                        ch_next = ch_reg + 1'b1;
                        st_next = ST_SEL;
                    end
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_next.status        = job_reg.status;
                    out_next.updated_mask  = job_reg.mask;
                    out_next.voltage_value = vals_reg[0];
                    out_next.current_value = vals_reg[1];
                    out_next.power_value   = vals_reg[2];
                    out_next.voltage_coef  = job_reg.words[0];
                    out_next.voltage_reg   = job_reg.words[1];
                    out_next.current_coef  = job_reg.words[2];
                    out_next.current_reg   = job_reg.words[3];
                    out_next.power_coef    = job_reg.words[4];
                    out_next.power_reg     = job_reg.words[5];
                    out_valid_next         = 1'b1;
                    st_next                = ST_IDLE;
                end
            end
            default:
            begin
                st_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid  = out_valid_reg;
    assign out_result = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= ST_IDLE;
            ch_reg        <= emfd_pkg::CH_VOLTAGE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg        <= st_next;
            ch_reg        <= ch_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg  <= job_next;
        vals_reg <= vals_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        out_reg  <= out_next;
    end

endmodule
`default_nettype wire

[hdl/energy_meter_frame_decode_core.sv]
// Top level of the energy meter frame decoder: configuration registers, front
// end, job queue and back end. Depends on emfd_pkg and the emfd_* modules.
//
// The block takes the bytes of a power-meter serial frame on the slave stream,
// one item per byte. An item with frame_start set is byte 0 of a new frame and
// latches the mode (measure or calibrate) from command; it always restarts the
// frame. Bytes 1 to 19 hold the check byte and six 24-bit big-endian words.
// Byte 20 carries the enable bits and closes the frame; it produces exactly one
// result item on the master stream. Bytes outside an open frame are dropped.
//
// The slave side takes one byte per cycle whenever the two-entry job queue has
// room, so a stalled receiver only holds up input once the back end holds a
// finished frame and two more frames wait in the queue behind it. The back end
// takes a job from the queue, runs each enabled measure channel through the
// shared restoring divider, settles a calibrate channel, a zero divisor or a
// disabled channel without it, and then loads the output register; it takes
// no new job until that register has taken the result.
//
// The configuration channel is always ready and writes register cfg_index
// (0 voltage_k, 1 current_k, 2 power_k; index 3 is ignored). Writes are to be
// made while no frame is being worked on; the block itself does not enforce
// this, so the user is bound to it. Reset clears the frame tracking, empties
// the queue, drops any pending result and restores the scale constants.
`default_nettype none
module energy_meter_frame_decode_core
(
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    // Input items.
    input  wire logic                                   s_tvalid,
    output logic                                        s_tready,
    // s_tdata: command [0], data_byte [8:1], frame_start [9], zero [15:10].
    input  wire logic [15:0]                            s_tdata,
    // Result items.
    output logic                                        m_tvalid,
    input  wire logic                                   m_tready,
    // m_tdata: status [1:0], updated_mask [4:2], voltage_value [44:5],
    // current_value [84:45], power_value [124:85], voltage_reg [148:125],
    // current_reg [172:149], power_reg [196:173], voltage_coef [220:197],
    // current_coef [244:221], power_coef [268:245], zero [271:269].
    output logic [271:0]                                m_tdata,
    // Configuration writes.
    input  wire logic                                   cfg_valid,
    output logic                                        cfg_ready,
    input  wire logic [emfd_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  wire logic [emfd_pkg::K_W-1:0]               cfg_data
);

    emfd_pkg::cfg_t    cfg_reg, cfg_next;
    emfd_pkg::job_t    push_job, head_job;
    emfd_pkg::result_t out_result;
    logic              in_accept;
    logic              push, pop, q_full, q_not_empty;

    // Scale constants.
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                emfd_pkg::CFG_VOLTAGE_K: cfg_next.voltage_k = cfg_data;
                emfd_pkg::CFG_CURRENT_K: cfg_next.current_k = cfg_data;
                emfd_pkg::CFG_POWER_K:   cfg_next.power_k   = cfg_data;
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.voltage_k <= emfd_pkg::VOLTAGE_K_RST;
            cfg_reg.current_k <= emfd_pkg::CURRENT_K_RST;
            cfg_reg.power_k   <= emfd_pkg::POWER_K_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Input is held off only when the queue cannot take another frame.
    assign s_tready  = !q_full;
    assign in_accept = s_tvalid && s_tready;

    emfd_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_accept   (in_accept),
        .command     (s_tdata[0]),
        .data_byte   (s_tdata[8:1]),
        .frame_start (s_tdata[9]),
        .push        (push),
        .push_job    (push_job)
    );

    emfd_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_job  (push_job),
        .pop       (pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head_job  (head_job)
    );

    emfd_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .job_avail  (q_not_empty),
        .head_job   (head_job),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (out_result)
    );

    assign m_tdata = {3'b000, out_result};

endmodule
`default_nettype wire
